@@ hdl/wat_pkg.sv @@
package wat_pkg;

  // Field widths of one input item
  localparam int SLOT_W  = 4;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int DAYS_W  = 7;
  localparam int TGT_W   = 2;
  localparam int TEMP_W  = 8;
  localparam int CODE_W  = 3;
  localparam int SECS_W  = 40;
  localparam int CFG_W   = 5;

  // Minute of the week fits in 14 bits; the all-ones code marks never fired
  localparam int MOW_W   = 14;
  localparam int WDAY_W  = 3;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;

  localparam int ENTRY_COUNT_DEF = 16;
  localparam int MAX_EXAMINE     = 16;

  localparam logic             MODE_WRITE   = 1'b0;
  localparam logic             MODE_TICK    = 1'b1;
  localparam logic [TGT_W-1:0] TGT_CLIMATE  = 2'd1;
  localparam logic [TGT_W-1:0] TGT_LAMP     = 2'd2;
  localparam logic [WDAY_W-1:0] LAST_WDAY   = 3'd6;

  localparam logic [MOW_W-1:0]  NEVER_FIRED  = 14'd16383;
  localparam logic [MOW_W-1:0]  MIN_PER_DAY  = 14'd1440;
  localparam logic [MOW_W-1:0]  MIN_PER_HOUR = 14'd60;
  localparam logic [TEMP_W-1:0] DEFAULT_TEMP = 8'd25;

  // Controller to datapath
  typedef struct packed {
    logic wr_entry;   // store the entry carried by the input transfer
    logic load_tick;  // capture tick time, rewind the scan index
    logic step;       // mark the current entry if it hits, advance the index
    logic load_pend;  // capture the current entry as the pending command
    logic push_out;   // move the pending command to the output register
    logic push_last;  // tag the pushed command as the last of the tick
  } wat_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_ok;   // input tick has a valid weekday and a nonzero scan length
    logic hit;        // current entry fires
    logic emit;       // current entry fires and has a command target
    logic scan_last;  // current entry is the last one to examine
  } wat_sts_t;

endpackage

@@ hdl/wat_dpath.sv @@
module wat_dpath
  import wat_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_valid,
  input  logic [CFG_W-1:0]      cfg_data,
  input  wat_cmd_t              cmd,
  output wat_sts_t              sts,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int DEPTH = (ENTRY_COUNT < MAX_EXAMINE) ? ENTRY_COUNT : MAX_EXAMINE;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(DEPTH);

  // Unpack input fields
  logic [SLOT_W-1:0] f_slot;
  logic              f_en;
  logic [HOUR_W-1:0] f_hour;
  logic [MIN_W-1:0]  f_min;
  logic [DAYS_W-1:0] f_days;
  logic [TGT_W-1:0]  f_tgt;
  logic              f_pwr;
  logic [TEMP_W-1:0] f_temp;
  logic [CODE_W-1:0] f_cmode;
  logic [CODE_W-1:0] f_fan;
  logic [SECS_W-1:0] f_secs;

  assign f_slot  = in_tdata[3:0];
  assign f_en    = in_tdata[4];
  assign f_hour  = in_tdata[9:5];
  assign f_min   = in_tdata[15:10];
  assign f_days  = in_tdata[22:16];
  assign f_tgt   = in_tdata[24:23];
  assign f_pwr   = in_tdata[25];
  assign f_temp  = in_tdata[33:26];
  assign f_cmode = in_tdata[36:34];
  assign f_fan   = in_tdata[39:37];
  assign f_secs  = in_tdata[79:40];

  // Alarm table
  logic [DEPTH-1:0]  en_r;
  logic [HOUR_W-1:0] hour_r  [DEPTH];
  logic [MIN_W-1:0]  min_r   [DEPTH];
  logic [DAYS_W-1:0] days_r  [DEPTH];
  logic [TGT_W-1:0]  tgt_r   [DEPTH];
  logic              pwr_r   [DEPTH];
  logic [TEMP_W-1:0] temp_r  [DEPTH];
  logic [CODE_W-1:0] cmode_r [DEPTH];
  logic [CODE_W-1:0] fan_r   [DEPTH];
  logic [SECS_W-1:0] exp_r   [DEPTH];
  logic [MOW_W-1:0]  last_r  [DEPTH];

  // Tick context and scan index
  logic [CFG_W-1:0]  cfg_lim_r;
  logic [CFG_W-1:0]  lim_r;
  logic [CFG_W-1:0]  idx_r;
  logic [HOUR_W-1:0] tk_hour_r;
  logic [MIN_W-1:0]  tk_min_r;
  logic [WDAY_W-1:0] tk_day_r;
  logic [SECS_W-1:0] tk_secs_r;
  logic [MOW_W-1:0]  tk_mow_r;

  // Pending command and output register
  logic [SLOT_W-1:0] pd_slot_r;
  logic              pd_lamp_r;
  logic              pd_pwr_r;
  logic [TEMP_W-1:0] pd_temp_r;
  logic [CODE_W-1:0] pd_cmode_r;
  logic [CODE_W-1:0] pd_fan_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic              o_lamp_r;
  logic              o_pwr_r;
  logic [TEMP_W-1:0] o_temp_r;
  logic [CODE_W-1:0] o_cmode_r;
  logic [CODE_W-1:0] o_fan_r;
  logic              o_last_r;

  logic [CFG_W-1:0]  lim_now;
  logic              wr_ok;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [MOW_W-1:0]  mow_now;
  logic              not_expired;
  logic              tgt_cmd;

  assign lim_now = (cfg_lim_r > DEPTH_C) ? DEPTH_C : cfg_lim_r;
  assign wr_ok   = ({1'b0, f_slot} < (SLOT_W+1)'(DEPTH));
  assign wr_idx  = f_slot[IDX_W-1:0];
  assign rd_idx  = idx_r[IDX_W-1:0];

  assign mow_now = MOW_W'(f_days[WDAY_W-1:0]) * MIN_PER_DAY
                 + MOW_W'(f_hour) * MIN_PER_HOUR
                 + MOW_W'(f_min);

  assign sts.start_ok = (f_days <= DAYS_W'(LAST_WDAY)) && (lim_now != '0);

  assign not_expired = (exp_r[rd_idx] == '0) || (tk_secs_r <= exp_r[rd_idx]);
  assign sts.hit = en_r[rd_idx] && not_expired
                && days_r[rd_idx][tk_day_r]
                && (hour_r[rd_idx] == tk_hour_r)
                && (min_r[rd_idx] == tk_min_r)
                && (last_r[rd_idx] != tk_mow_r);
  assign tgt_cmd  = (tgt_r[rd_idx] == TGT_CLIMATE) || (tgt_r[rd_idx] == TGT_LAMP);
  assign sts.emit = sts.hit && tgt_cmd;
  assign sts.scan_last = ((idx_r + CFG_W'(1)) == lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= '0;
      cfg_lim_r <= '0;
      idx_r     <= '0;
    end else begin
      if (cfg_valid) begin
        cfg_lim_r <= cfg_data;
      end
      if (cmd.wr_entry && wr_ok) begin
        en_r[wr_idx] <= f_en;
      end
      if (cmd.load_tick) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + CFG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry && wr_ok) begin
      hour_r[wr_idx]  <= f_hour;
      min_r[wr_idx]   <= f_min;
      days_r[wr_idx]  <= f_days;
      tgt_r[wr_idx]   <= f_tgt;
      pwr_r[wr_idx]   <= f_pwr;
      temp_r[wr_idx]  <= f_temp;
      cmode_r[wr_idx] <= f_cmode;
      fan_r[wr_idx]   <= f_fan;
      exp_r[wr_idx]   <= f_secs;
      last_r[wr_idx]  <= NEVER_FIRED;
    end else if (cmd.step && sts.hit) begin
      last_r[rd_idx]  <= tk_mow_r;
    end
    if (cmd.load_tick) begin
      lim_r     <= lim_now;
      tk_hour_r <= f_hour;
      tk_min_r  <= f_min;
      tk_day_r  <= f_days[WDAY_W-1:0];
      tk_secs_r <= f_secs;
      tk_mow_r  <= mow_now;
    end
    if (cmd.push_out) begin
      o_slot_r  <= pd_slot_r;
      o_lamp_r  <= pd_lamp_r;
      o_pwr_r   <= pd_pwr_r;
      o_temp_r  <= pd_temp_r;
      o_cmode_r <= pd_cmode_r;
      o_fan_r   <= pd_fan_r;
      o_last_r  <= cmd.push_last;
    end
    if (cmd.load_pend) begin
      pd_slot_r  <= SLOT_W'(idx_r);
      pd_lamp_r  <= (tgt_r[rd_idx] == TGT_LAMP);
      pd_pwr_r   <= pwr_r[rd_idx];
      pd_temp_r  <= (temp_r[rd_idx] == '0) ? DEFAULT_TEMP : temp_r[rd_idx];
      pd_cmode_r <= cmode_r[rd_idx];
      pd_fan_r   <= fan_r[rd_idx];
    end
  end

  assign out_tdata = {5'b0, o_fan_r, o_cmode_r, o_temp_r, o_pwr_r, o_slot_r};
  assign out_tuser = o_lamp_r;
  assign out_tlast = o_last_r;

endmodule

@@ hdl/wat_ctrl.sv @@
module wat_ctrl
  import wat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tuser,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  wat_sts_t sts,
  output wat_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   pend_valid_r, pend_valid_nxt;
  logic   out_free;
  logic   in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    pend_valid_nxt = pend_valid_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == MODE_WRITE) begin
            cmd.wr_entry = 1'b1;
          end else begin
            cmd.load_tick = 1'b1;
            if (sts.start_ok) begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // hold the index while a second command waits on a full output
        if (!(sts.emit && pend_valid_r && !out_free)) begin
          cmd.step = 1'b1;
          if (sts.emit) begin
            cmd.load_pend  = 1'b1;
            cmd.push_out   = pend_valid_r;
            pend_valid_nxt = 1'b1;
          end
          if (sts.scan_last) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          cmd.push_out   = 1'b1;
          cmd.push_last  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.push_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

endmodule

@@ hdl/weekly_alarm_table_matcher.sv @@
// Channel  Signals                         Content
// in       in_tvalid/in_tready             tuser: mode; tdata: alarm entry or tick time
// out      out_tvalid/out_tready           tuser: lamp flag; tlast: last command of tick
// cfg      cfg_valid/cfg_ready             cfg_data: entries_in_use
//
// A write transfer stores one entry. A tick is captured first, then each examined
// entry (entries_in_use, capped at the table size) is read in turn through
// the single table read port, then the last command is released;
// a tick with an invalid weekday or nothing to examine ends once captured.
// A stalled output holds the scan when a second command is ready, and holds the release.
// Reset disables all entries and clears entries_in_use.
module weekly_alarm_table_matcher
  import wat_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] slot_index, [4] enable_flag, [9:5] hour_value, [15:10] minute_value,
  // [22:16] day_bits, [24:23] target_code, [25] power_on, [33:26] temp_setting,
  // [36:34] climate_mode, [39:37] fan_speed, [79:40] time_seconds
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] fired_slot, [4] fired_power, [12:5] fired_temp, [15:13] fired_mode,
  // [18:16] fired_fan, [23:19] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] fired_target
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  wat_cmd_t cmd;
  wat_sts_t sts;

  assign cfg_ready = 1'b1;

  wat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wat_dpath #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
